@@ rtl/core/piq_pkg.sv @@
// Shared types and constants for the positional insert queue.
package piq_pkg;

  localparam int DEPTH         = 16;
  localparam int COORD_W       = 16;
  localparam int COORD_FIELD_W = 16;
  localparam int POS_W         = 5;
  localparam int CNT_OUT_W     = 5;
  localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int CMP_W         = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                            mode;
    logic signed [COORD_FIELD_W-1:0]  item_x;
    logic signed [COORD_FIELD_W-1:0]  item_y;
    logic        [POS_W-1:0]          position;
  } req_t;

  typedef struct packed {
    logic signed [COORD_FIELD_W-1:0]  out_x;
    logic signed [COORD_FIELD_W-1:0]  out_y;
    logic                             found;
    logic        [CNT_OUT_W-1:0]      count;
    status_t                          status;
  } rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pair_t;

  // Broadcast to every cell of the row each cycle.
  typedef struct packed {
    logic             ins;    // insert key at slot, later cells shift back
    logic             rem;    // drop head, each cell takes its right neighbor, the last cell keeps its own
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] count;  // occupancy before this request
    pair_t            key;
  } cmd_t;

endpackage

@@ rtl/core/positional_insert_queue_unit.sv @@
// Top level of the positional insert queue: decode, occupancy, result register.
// Latency: a request is decoded and applied to the cell row in the cycle it is
// accepted; its response is valid in the next cycle from a result register.
// Throughput: one request per cycle, set by the shift/compare of the cell row;
// a waiting response only stalls intake when it is not taken.
// Reset (rst, synchronous): count clears to zero and no response is pending.
module positional_insert_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  piq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output piq_pkg::rsp_t rsp
);

  logic                       accept;
  logic [piq_pkg::CNT_W-1:0]  count;
  logic [piq_pkg::CNT_W-1:0]  count_next;
  piq_pkg::cmd_t              cmd;
  piq_pkg::pair_t             head;
  logic                       hit_any;
  piq_pkg::rsp_t              rsp_next;
  logic                       full;
  logic                       empty;
  logic                       pos_bad;

  // Result register parts the two sides: take a new request whenever the
  // held response is gone or leaves this cycle.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign full    = (count == piq_pkg::CNT_W'(piq_pkg::DEPTH));
  assign empty   = (count == '0);
  assign pos_bad = piq_pkg::CMP_W'(req.position) > piq_pkg::CMP_W'(count);

  // Decode: choose the cell-row command and the response fields.
  // Range check on insert goes before the full check.
  always_comb begin
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.slot   = count;
    cmd.count  = count;
    cmd.key.x  = req.item_x[piq_pkg::COORD_W-1:0];
    cmd.key.y  = req.item_y[piq_pkg::COORD_W-1:0];
    count_next = count;

    rsp_next.out_x  = '0;
    rsp_next.out_y  = '0;
    rsp_next.found  = 1'b0;
    rsp_next.status = piq_pkg::ST_OK;

    case (req.mode)
      piq_pkg::MODE_APPEND: begin
        if (full) begin
          rsp_next.status = piq_pkg::ST_FULL;
        end else begin
          cmd.ins    = accept;
          count_next = piq_pkg::CNT_W'(count + 1'b1);
        end
      end
      piq_pkg::MODE_INSERT: begin
        if (pos_bad) begin
          rsp_next.status = piq_pkg::ST_RANGE;
        end else if (full) begin
          rsp_next.status = piq_pkg::ST_FULL;
        end else begin
          cmd.ins    = accept;
          cmd.slot   = piq_pkg::CNT_W'(req.position);
          count_next = piq_pkg::CNT_W'(count + 1'b1);
        end
      end
      piq_pkg::MODE_REMOVE: begin
        if (empty) begin
          rsp_next.status = piq_pkg::ST_EMPTY;
        end else begin
          cmd.rem        = accept;
          rsp_next.out_x = piq_pkg::COORD_FIELD_W'(head.x);
          rsp_next.out_y = piq_pkg::COORD_FIELD_W'(head.y);
          count_next     = piq_pkg::CNT_W'(count - 1'b1);
        end
      end
      piq_pkg::MODE_SEARCH: begin
        rsp_next.found = hit_any;
      end
      default: begin
      end
    endcase

    rsp_next.count = piq_pkg::CNT_OUT_W'(count_next);
  end

  piq_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .head    (head),
    .hit_any (hit_any)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/core/piq_cell.sv @@
// One storage cell of the queue row: holds a pair, shifts, compares.
module piq_cell (
  input  logic                      clk,
  input  piq_pkg::cmd_t             cmd,
  input  logic [piq_pkg::IDX_W-1:0] idx,
  input  piq_pkg::pair_t            prev_data,
  input  piq_pkg::pair_t            next_data,
  output piq_pkg::pair_t            data,
  output logic                      hit
);

  logic [piq_pkg::CNT_W-1:0] idx_ext;

  assign idx_ext = piq_pkg::CNT_W'(idx);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (idx_ext == cmd.slot) begin
        data <= cmd.key;
      end else if (idx_ext > cmd.slot) begin
        data <= prev_data;
      end
    end else if (cmd.rem) begin
      data <= next_data;
    end
  end

  // Only occupied cells may report a match.
  assign hit = (data == cmd.key) && (idx_ext < cmd.count);

endmodule

@@ rtl/core/piq_chain.sv @@
// Row of queue cells, slot 0 at the head, with the match reduction.
module piq_chain (
  input  logic           clk,
  input  piq_pkg::cmd_t  cmd,
  output piq_pkg::pair_t head,
  output logic           hit_any
);

  piq_pkg::pair_t             cell_data [piq_pkg::DEPTH];
  logic [piq_pkg::DEPTH-1:0]  hit;

  for (genvar i = 0; i < piq_pkg::DEPTH; i++) begin : g_cell
    piq_pkg::pair_t prev_d;
    piq_pkg::pair_t next_d;

    if (i == 0) begin : g_first
      assign prev_d = cmd.key;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == piq_pkg::DEPTH - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    piq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (piq_pkg::IDX_W'(i)),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .hit       (hit[i])
    );
  end

  assign head    = cell_data[0];
  assign hit_any = |hit;

endmodule

@@ rtl/core/piq_checker.sv @@
// Port-level checks for the positional insert queue, bound to the top level.
module piq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input piq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input piq_pkg::rsp_t rsp
);

  // Held response stays put until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // A rejected request returns no pair and no match.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != piq_pkg::ST_OK |->
      rsp.out_x == '0 && rsp.out_y == '0 && !rsp.found)
    else $error("error response carries data");

  // Full rejection only at capacity, empty rejection only at zero.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == piq_pkg::ST_FULL || rsp.status == piq_pkg::ST_EMPTY) |->
      (rsp.status == piq_pkg::ST_FULL &&
       rsp.count == piq_pkg::CNT_OUT_W'(piq_pkg::DEPTH)) ||
      (rsp.status == piq_pkg::ST_EMPTY && rsp.count == '0))
    else $error("status disagrees with count");

  // A match needs a stored pair.
  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.count != '0 && rsp.status == piq_pkg::ST_OK)
    else $error("match reported on empty queue");

  // Nothing pending straight out of reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind positional_insert_queue_unit piq_checker u_piq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

@@ test/testbench.sv @@
// Self-checking testbench for the positional insert queue unit.
`timescale 1ns / 100ps

module testbench;
  import piq_pkg::*;

  // Generous ceiling: ~700 requests, each at worst a sender gap plus
  // a long receiver stall, take well under CYCLE_LIMIT.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int PRINT_LIMIT   = 100;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} traffic_bias_e;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  rsp_t  rsp;

  positional_insert_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Shadow copy of the queue contents; only slots below queue_fill are valid.
  pair_t       queue_slots [DEPTH];
  int unsigned queue_fill = 0;

  rsp_t        expected_responses [$];
  int          error_count    = 0;
  int          response_index = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  logic [8:0]  stall_tick     = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Response side back-pressure: cycles through always-ready, coin-flip,
  // mostly-stalled and a fixed 5-of-8 pattern in turn.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[8:7])
      2'd0:    rsp_ready <= 1'b1;
      2'd1:    rsp_ready <= 1'($urandom_range(1));
      2'd2:    rsp_ready <= ($urandom_range(3) == 0);
      default: rsp_ready <= (stall_tick[2:0] < 3'd5);
    endcase
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("MISMATCH response %0d %s: got %0h expected %0h",
               response_index, what, got, want);
  endtask

  // Shift slots at and after `slot` back by one and store the new pair.
  function automatic void place_pair(input int unsigned slot, input pair_t p);
    for (int unsigned i = queue_fill; i > slot; i--)
      queue_slots[i] = queue_slots[i-1];
    queue_slots[slot] = p;
    queue_fill++;
  endfunction

  // Apply one request to the shadow queue and return the response it yields.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t  res;
    pair_t key;
    res        = '0;
    res.status = ST_OK;
    key.x      = r.item_x;
    key.y      = r.item_y;
    case (r.mode)
      MODE_APPEND: begin
        if (queue_fill >= DEPTH) res.status = ST_FULL;
        else place_pair(queue_fill, key);
      end
      MODE_INSERT: begin
        // Range is checked ahead of capacity.
        if (r.position > queue_fill) res.status = ST_RANGE;
        else if (queue_fill >= DEPTH) res.status = ST_FULL;
        else place_pair(r.position, key);
      end
      MODE_REMOVE: begin
        if (queue_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_x = queue_slots[0].x;
          res.out_y = queue_slots[0].y;
          for (int unsigned i = 1; i < queue_fill; i++)
            queue_slots[i-1] = queue_slots[i];
          queue_fill--;
        end
      end
      default: begin
        for (int unsigned i = 0; i < queue_fill; i++)
          if (queue_slots[i] == key) res.found = 1'b1;
      end
    endcase
    res.count = queue_fill[CNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic req_t make_req(input mode_t m, input logic [15:0] x,
                                    input logic [15:0] y, input logic [4:0] pos);
    req_t r;
    r.mode     = m;
    r.item_x   = x;
    r.item_y   = y;
    r.position = pos;
    return r;
  endfunction

  // Drive one request and hold it until accepted. Ready is sampled on the
  // falling edge so the decision never races the DUT's own clock edge.
  // The wait loop ends on the rising edge where the request was taken.
  task automatic send_request(input req_t r);
    bit taken;
    req       <= r;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = (req_ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    expected_responses.push_back(apply_request(r));
    // Bursty sender: short or long runs back to back, then a random gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(1) == 0) ? $urandom_range(4) : $urandom_range(40, 10);
    end
  endtask

  // Hold off new requests until every outstanding response has come back.
  // At least one edge passes, so the next request drive lands in a later step.
  task automatic wait_for_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_responses.size() != 0);
  endtask

  // Response checker: compare each accepted response against the oldest
  // prediction, field by field.
  always @(negedge clk) begin : check_responses
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("response with nothing pending", rsp.count, '0);
      end else begin
        want = expected_responses.pop_front();
        if (rsp.out_x !== want.out_x)   report_mismatch("out_x", rsp.out_x, want.out_x);
        if (rsp.out_y !== want.out_y)   report_mismatch("out_y", rsp.out_y, want.out_y);
        if (rsp.found !== want.found)   report_mismatch("found", rsp.found, want.found);
        if (rsp.count !== want.count)   report_mismatch("count", rsp.count, want.count);
        if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
      end
      response_index++;
    end
  end

  // Empty queue: remove, search and an insert beyond the (zero) count.
  task automatic test_empty_queue();
    send_request(make_req(MODE_REMOVE, 16'h1111, 16'h2222, 5'd0));
    send_request(make_req(MODE_SEARCH, 16'h0000, 16'h0000, 5'd0));
    send_request(make_req(MODE_INSERT, 16'h0001, 16'h0001, 5'd1));
  endtask

  // Most negative / most positive coordinates through append and remove.
  task automatic test_extreme_values();
    send_request(make_req(MODE_APPEND, 16'h8000, 16'h7fff, 5'd0));
    send_request(make_req(MODE_APPEND, 16'h7fff, 16'h8000, 5'd0));
    send_request(make_req(MODE_REMOVE, 16'h0000, 16'h0000, 5'd0));
  endtask

  // Insert at head, at tail (position == count), in the middle, then two
  // out-of-range positions: the largest encodable and count + 1.
  task automatic test_positional_insert();
    send_request(make_req(MODE_INSERT, 16'h0000, 16'hffff, 5'd0));
    send_request(make_req(MODE_INSERT, 16'h1234, 16'hfffe, 5'd2));
    send_request(make_req(MODE_INSERT, 16'hffff, 16'h0000, 5'd1));
    send_request(make_req(MODE_INSERT, 16'h5555, 16'haaaa, 5'd31));
    send_request(make_req(MODE_INSERT, 16'h5555, 16'haaaa, 5'd5));
  endtask

  // Hit in the middle, near miss on y only, hit at the tail.
  task automatic test_search();
    send_request(make_req(MODE_SEARCH, 16'hffff, 16'h0000, 5'd0));
    send_request(make_req(MODE_SEARCH, 16'hffff, 16'hffff, 5'd0));
    send_request(make_req(MODE_SEARCH, 16'h1234, 16'hfffe, 5'd0));
  endtask

  // Fill to capacity, then append and insert when full; a position past the
  // count still reports range ahead of full.
  task automatic test_capacity();
    while (queue_fill < DEPTH)
      send_request(make_req(MODE_APPEND, 16'($urandom), 16'($urandom), 5'($urandom)));
    send_request(make_req(MODE_APPEND, 16'h4321, 16'h8765, 5'd0));
    send_request(make_req(MODE_INSERT, 16'h4321, 16'h8765, 5'd16));
    send_request(make_req(MODE_INSERT, 16'h4321, 16'h8765, 5'd17));
  endtask

  // Coordinates: mostly random, with extremes and a tiny pool so that
  // duplicates and search hits happen often.
  function automatic logic [15:0] random_coord();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    if (roll < 40) return 16'($urandom_range(3));
    return 16'($urandom);
  endfunction

  function automatic req_t random_request(input traffic_bias_e bias);
    req_t        r;
    int unsigned roll;
    int unsigned add_w;
    int unsigned rem_w;
    int unsigned pick;
    case (bias)
      BIAS_FILL:  begin add_w = 35; rem_w = 10; end
      BIAS_DRAIN: begin add_w = 10; rem_w = 55; end
      default:    begin add_w = 25; rem_w = 25; end
    endcase
    r = make_req(MODE_SEARCH, random_coord(), random_coord(), 5'($urandom));
    roll = $urandom_range(99);
    if (roll < add_w)             r.mode = MODE_APPEND;
    else if (roll < 2 * add_w)    r.mode = MODE_INSERT;
    else if (roll < 2 * add_w + rem_w) r.mode = MODE_REMOVE;
    else                          r.mode = MODE_SEARCH;

    // Inserts mostly land in range; the rest use any encodable position.
    if (r.mode == MODE_INSERT && $urandom_range(9) < 8)
      r.position = 5'($urandom_range(queue_fill));

    // Searches: stored pair, near miss on one coordinate, or random key.
    if (r.mode == MODE_SEARCH && queue_fill > 0) begin
      roll = $urandom_range(99);
      pick = $urandom_range(queue_fill - 1);
      if (roll < 50) begin
        r.item_x = queue_slots[pick].x;
        r.item_y = queue_slots[pick].y;
      end else if (roll < 70) begin
        r.item_x = queue_slots[pick].x;
        r.item_y = queue_slots[pick].y ^ (16'h1 << $urandom_range(15));
      end
    end
    return r;
  endfunction

  // Random traffic in 40-request phases that alternately fill, drain and
  // mix, so the count sweeps between empty and full many times.
  task automatic test_random_traffic();
    traffic_bias_e bias;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 40) % 3)
        0:       bias = BIAS_FILL;
        1:       bias = BIAS_DRAIN;
        default: bias = BIAS_MIXED;
      endcase
      // One quiet point mid-run: let the pipeline empty completely.
      if (n == RANDOM_ITEMS / 2) wait_for_responses();
      send_request(random_request(bias));
    end
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    rsp_ready <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_extreme_values();
    test_positional_insert();
    test_search();
    test_capacity();
    wait_for_responses();
    test_random_traffic();

    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0)
      report_mismatch("responses never returned", expected_responses.size(), '0);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
